FILE: src/ptw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-level page table walker.
// Used by ptw_ctrl, ptw_datapath and the top level; depends on nothing else.
package ptw_pkg;

    // Table store geometry.
    localparam int TABLE_WORDS = 4096;
    localparam int WORD_AW     = $clog2(TABLE_WORDS);
    localparam int SUM_W       = WORD_AW + 1;

    // Field widths.
    localparam int ADDR_W  = 52;
    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int OFS_W   = 12;
    localparam int IDX_W   = 9;
    localparam int LVL_W   = 2;

    localparam logic [LVL_W-1:0] LEAF_LEVEL = LVL_W'(3);

    // Reset value of both address registers.
    localparam logic [ADDR_W-1:0] ADDR_RESET = ADDR_W'(64'h20_0000);

    // Operation codes.
    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_MAP       = 2'd1;
    localparam logic [1:0] MODE_UNMAP     = 2'd2;
    localparam logic [1:0] MODE_RAW       = 2'd3;

    // Result codes.
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_ABSENT     = 3'd1;
    localparam logic [2:0] STATUS_MISALIGNED = 3'd2;
    localparam logic [2:0] STATUS_CONFLICT   = 3'd3;
    localparam logic [2:0] STATUS_WINDOW     = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_ROOT_TABLE = 1'b0;
    localparam logic CFG_TABLE_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [VA_W-1:0]    virt_addr;
        logic [ADDR_W-1:0]  phys_page;
        logic [7:0]         page_flags;
        logic [11:0]        word_index;
        logic [ENTRY_W-1:0] word_value;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] phys_out;
        logic [2:0]         status;
        logic               invalidate;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOCATE,
        S_FETCH,
        S_WRITE,
        S_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic start;
        logic locate;
        logic check;
        logic write;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clear_last;
        logic [1:0] req_mode;
        logic       req_misaligned;
        logic [1:0] mode;
        logic       loc_fail;
        logic       entry_present;
        logic       last_level;
        logic       conflict;
        logic       out_free;
    } dp_sts_t;

endpackage

FILE: src/ptw_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the page table walker.
// Sequences clearing, the four-level walk, leaf writes and raw writes; uses ptw_pkg.
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (sts.req_mode == MODE_RAW)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (sts.req_misaligned)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LOCATE;
                    end
                end
            end
            S_LOCATE:
            begin
                state_next = sts.loc_fail ? S_FINISH : S_FETCH;
            end
            S_FETCH:
            begin
                if (!sts.last_level)
                begin
                    state_next = sts.entry_present ? S_LOCATE : S_FINISH;
                end
                else if ((sts.mode == MODE_MAP && !sts.conflict) ||
                         sts.mode == MODE_UNMAP)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_WRITE:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            S_LOCATE:
            begin
                cmd.locate = 1'b1;
            end
            S_FETCH:
            begin
                cmd.check = 1'b1;
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/ptw_datapath.sv
`timescale 1ns / 1ps
// Datapath of the page table walker: configuration registers, table store,
// address location per level, result and output registers; uses ptw_pkg.
module ptw_datapath
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  ctrl_cmd_t         cmd,
    output dp_sts_t           sts
);

    // Table store.
    logic [ENTRY_W-1:0] mem [TABLE_WORDS];
    logic               mem_we;
    logic [WORD_AW-1:0] mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] rdata_reg;

    // Registers.
    logic [ADDR_W-1:0]  root_table_reg, root_table_next;
    logic [ADDR_W-1:0]  table_base_reg, table_base_next;
    logic [WORD_AW-1:0] clr_reg, clr_next;
    req_t               item_reg, item_next;
    logic [ENTRY_W-1:0] table_reg, table_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [WORD_AW-1:0] addr_reg, addr_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [ENTRY_W-1:0] res_phys_reg, res_phys_next;
    logic               res_inval_reg, res_inval_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // Combinational helpers.
    logic [ENTRY_W-1:0] base_ext;
    logic [ENTRY_W-1:0] diff;
    logic [IDX_W-1:0]   level_idx;
    logic [SUM_W-1:0]   word_sum;
    logic               loc_fail;
    logic [WORD_AW-1:0] loc_word;
    logic [ENTRY_W-1:0] want;
    logic               raw_ok;
    logic [WORD_AW-1:0] raw_word;

    // Locate the entry's store word in the current table.
    always_comb
    begin
        base_ext = {{(ENTRY_W - ADDR_W){1'b0}}, table_base_reg};
        diff     = table_reg - base_ext;
        case (level_reg)
            2'd0:    level_idx = item_reg.virt_addr[47:39];
            2'd1:    level_idx = item_reg.virt_addr[38:30];
            2'd2:    level_idx = item_reg.virt_addr[29:21];
            default: level_idx = item_reg.virt_addr[20:12];
        endcase
        word_sum = {1'b0, diff[WORD_AW+2:3]} + SUM_W'(level_idx);
        loc_fail = (table_reg < base_ext) ||
                   (diff[ENTRY_W-1:3] >= (ENTRY_W - 3)'(TABLE_WORDS)) ||
                   (word_sum >= SUM_W'(TABLE_WORDS));
        loc_word = word_sum[WORD_AW-1:0];
    end

    // Leaf value for a map, and the raw write target.
    assign want     = {{(ENTRY_W - ADDR_W){1'b0}}, item_reg.phys_page} |
                      {{(ENTRY_W - 8){1'b0}}, item_reg.page_flags};
    assign raw_ok   = 32'(item_reg.word_index) < 32'(TABLE_WORDS);
    assign raw_word = WORD_AW'(item_reg.word_index);

    // Status towards the controller.
    always_comb
    begin
        sts.clear_last     = (clr_reg == WORD_AW'(TABLE_WORDS - 1));
        sts.req_mode       = req.mode;
        sts.req_misaligned = (req.mode == MODE_MAP || req.mode == MODE_UNMAP) &&
                             (req.virt_addr[OFS_W-1:0] != '0);
        sts.mode           = item_reg.mode;
        sts.loc_fail       = loc_fail;
        sts.entry_present  = rdata_reg[0];
        sts.last_level     = (level_reg == LEAF_LEVEL);
        sts.conflict       = rdata_reg[0] && (rdata_reg != want);
        sts.out_free       = !rsp_valid_reg || rsp_ready;
    end

    // Store write port: clearing sweep, raw write or leaf write.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
        end
        else if (cmd.write)
        begin
            if (item_reg.mode == MODE_RAW)
            begin
                mem_we    = raw_ok;
                mem_waddr = raw_word;
                mem_wdata = item_reg.word_value;
            end
            else
            begin
                mem_we    = 1'b1;
                mem_wdata = (item_reg.mode == MODE_MAP) ? want : '0;
            end
        end
    end

    // Table store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.locate)
        begin
            rdata_reg <= mem[loc_word];
        end
    end

    // Next values of the walk, result and output registers.
    always_comb
    begin
        root_table_next = root_table_reg;
        table_base_next = table_base_reg;
        clr_next        = clr_reg;
        item_next       = item_reg;
        table_next      = table_reg;
        level_next      = level_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_phys_next   = res_phys_reg;
        res_inval_next  = res_inval_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        if (cfg_write)
        begin
            if (cfg_index == CFG_ROOT_TABLE)
            begin
                root_table_next = cfg_data;
            end
            else
            begin
                table_base_next = cfg_data;
            end
        end

        if (cmd.clear_step)
        begin
            clr_next = clr_reg + 1'b1;
        end

        if (cmd.start)
        begin
            item_next      = req;
            table_next     = {{(ENTRY_W - ADDR_W){1'b0}},
                              root_table_reg[ADDR_W-1:OFS_W], {OFS_W{1'b0}}};
            level_next     = '0;
            res_phys_next  = '0;
            res_inval_next = 1'b0;
            if (sts.req_misaligned)
            begin
                res_status_next = STATUS_MISALIGNED;
            end
            else if (req.mode == MODE_RAW &&
                     32'(req.word_index) >= 32'(TABLE_WORDS))
            begin
                res_status_next = STATUS_WINDOW;
            end
            else
            begin
                res_status_next = STATUS_OK;
            end
        end

        if (cmd.locate)
        begin
            addr_next = loc_word;
            if (loc_fail)
            begin
                res_status_next = STATUS_WINDOW;
            end
        end

        // Examine the fetched entry.
        if (cmd.check)
        begin
            if (level_reg != LEAF_LEVEL)
            begin
                if (rdata_reg[0])
                begin
                    table_next = {rdata_reg[ENTRY_W-1:OFS_W], {OFS_W{1'b0}}};
                    level_next = level_reg + 1'b1;
                end
                else
                begin
                    res_status_next = STATUS_ABSENT;
                end
            end
            else if (item_reg.mode == MODE_TRANSLATE)
            begin
                if (rdata_reg[0])
                begin
                    res_phys_next = {rdata_reg[ENTRY_W-1:OFS_W],
                                     item_reg.virt_addr[OFS_W-1:0]};
                end
                else
                begin
                    res_status_next = STATUS_ABSENT;
                end
            end
            else if (item_reg.mode == MODE_MAP && sts.conflict)
            begin
                res_status_next = STATUS_CONFLICT;
            end
        end

        if (cmd.write)
        begin
            res_inval_next = (item_reg.mode != MODE_RAW);
        end

        // Hand the result to the output register.
        if (cmd.finish)
        begin
            rsp_next.phys_out   = res_phys_reg;
            rsp_next.status     = res_status_reg;
            rsp_next.invalidate = res_inval_reg;
            rsp_valid_next      = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_table_reg <= ADDR_RESET;
            table_base_reg <= ADDR_RESET;
            clr_reg        <= '0;
            level_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            root_table_reg <= root_table_next;
            table_base_reg <= table_base_next;
            clr_reg        <= clr_next;
            level_reg      <= level_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        table_reg      <= table_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_phys_reg   <= res_phys_next;
        res_inval_reg  <= res_inval_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// Four-level x86-64 page table walker over an internal store of 4096 64-bit
// entries. After reset the block clears the store, one word a cycle, and
// meanwhile accepts no request beat (configuration writes are taken as usual).
// Each level of a walk passes through the LOCATE state, which works out the
// store word from the table address and index and issues the synchronous
// store read, and the FETCH state, which examines the entry, so the four
// dependent reads set the pace. A map or unmap then writes the leaf; a walk
// may stop early, a misaligned map or unmap skips the walk, and a raw write
// goes straight to the store write. One request is in flight at a time; a new
// beat is accepted while the previous result waits in the output register.
module four_level_page_table_walker
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Sequencing.
    ptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store and walk datapath.
    ptw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A leaf is only reported as changed on a successful operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.invalidate |-> rsp.status == STATUS_OK)
        else $error("invalidate beat with a failing status");

    // A translated address only goes out with a good status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.phys_out != '0 |-> rsp.status == STATUS_OK)
        else $error("nonzero address beat with a failing status");

    // Status codes beyond the window code never appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= STATUS_WINDOW)
        else $error("undefined status code on result beat");

endmodule

FILE: tb/sv/four_level_page_table_walker_checker.sv
`timescale 1ns / 1ps
// Result checker for the four-level page table walker: keeps its own copy of
// the table store and the address registers, predicts each result beat and
// compares it with the block. Depends on ptw_pkg only.
module four_level_page_table_walker_checker
    import ptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              req_valid,
    input  logic              req_ready,
    input  req_t              req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_t              rsp,
    output int                mismatches,
    output int                walks_outstanding
);

    localparam logic [63:0] PAGE_MASK = 64'hFFF;
    localparam int          REPORT_MAX = 10;

    logic [ENTRY_W-1:0] mirror_store [TABLE_WORDS];
    logic [63:0]        root_addr;
    logic [63:0]        base_addr;
    rsp_t               results_due [$];

    // Locate the store word of entry idx in the table at physical address tbl.
    // Tables below the window or past its end stop the walk.
    function automatic logic [2:0] find_word(input logic [63:0] tbl, input logic [8:0] idx,
                                             output logic [WORD_AW-1:0] word);
        logic [63:0] ofs;
        word = '0;
        if (tbl < base_addr)
            return STATUS_WINDOW;
        ofs = (tbl - base_addr) >> 3;
        if (ofs >= 64'(TABLE_WORDS))
            return STATUS_WINDOW;
        ofs = ofs + 64'(idx);
        if (ofs >= 64'(TABLE_WORDS))
            return STATUS_WINDOW;
        word = ofs[WORD_AW-1:0];
        return STATUS_OK;
    endfunction

    // Walk the three upper levels, each of which must be present, and find
    // the store word that holds the leaf entry.
    function automatic logic [2:0] walk_to_leaf(input logic [VA_W-1:0] va,
                                                output logic [WORD_AW-1:0] leaf);
        logic [63:0]        tbl;
        logic [WORD_AW-1:0] word;
        logic [2:0]         st;
        tbl  = root_addr & ~PAGE_MASK;
        leaf = '0;
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            st = find_word(tbl, 9'(va >> (39 - 9 * lvl)), word);
            if (st != STATUS_OK)
                return st;
            if (!mirror_store[word][0])
                return STATUS_ABSENT;
            tbl = mirror_store[word] & ~PAGE_MASK;
        end
        return find_word(tbl, va[20:12], leaf);
    endfunction

    // Work out the result of one request beat and apply its side effects to
    // the mirrored store.
    function automatic rsp_t walk_request(input req_t r);
        rsp_t               res;
        logic [WORD_AW-1:0] leaf;
        logic [63:0]        entry;
        logic [63:0]        want;
        res  = '0;
        leaf = '0;
        case (r.mode)
            MODE_RAW:
            begin
                if (r.word_index < TABLE_WORDS)
                    mirror_store[r.word_index] = r.word_value;
                else
                    res.status = STATUS_WINDOW;
            end
            MODE_TRANSLATE:
            begin
                res.status = walk_to_leaf(r.virt_addr, leaf);
                if (res.status == STATUS_OK)
                begin
                    entry = mirror_store[leaf];
                    if (!entry[0])
                        res.status = STATUS_ABSENT;
                    else
                        res.phys_out = 64'(r.virt_addr[11:0]) + (entry & ~PAGE_MASK);
                end
            end
            MODE_MAP, MODE_UNMAP:
            begin
                if (r.virt_addr[11:0] != '0)
                    res.status = STATUS_MISALIGNED;
                else
                begin
                    res.status = walk_to_leaf(r.virt_addr, leaf);
                    if (res.status == STATUS_OK && r.mode == MODE_MAP)
                    begin
                        want  = 64'(r.phys_page) | 64'(r.page_flags);
                        entry = mirror_store[leaf];
                        // A present leaf may only be rewritten with the same value.
                        if (entry[0] && entry != want)
                            res.status = STATUS_CONFLICT;
                        else
                        begin
                            mirror_store[leaf] = want;
                            res.invalidate     = 1'b1;
                        end
                    end
                    else if (res.status == STATUS_OK)
                    begin
                        mirror_store[leaf] = '0;
                        res.invalidate     = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Follow register writes, predict on every request beat and compare every
    // result beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_t want;
        if (!rst_n)
        begin
            foreach (mirror_store[i])
                mirror_store[i] = '0;
            root_addr = 64'(ADDR_RESET);
            base_addr = 64'(ADDR_RESET);
            results_due.delete();
            walks_outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_ROOT_TABLE)
                    root_addr = 64'(cfg_data);
                else
                    base_addr = 64'(cfg_data);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (results_due.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: unexpected result: phys %h st %0d inv %0b",
                                 $time, rsp.phys_out, rsp.status, rsp.invalidate);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp.phys_out !== want.phys_out || rsp.status !== want.status ||
                        rsp.invalidate !== want.invalidate)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t: expected %h/%0d/%0b got %h/%0d/%0b",
                                     $time, want.phys_out, want.status,
                                     want.invalidate, rsp.phys_out, rsp.status,
                                     rsp.invalidate);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
                results_due.push_back(walk_request(req));
            walks_outstanding <= results_due.size();
        end
    end

endmodule

FILE: tb/sv/four_level_page_table_walker_test.sv
`timescale 1ns / 1ps
// Top of the page table walker testbench: clock, reset, register writes,
// request and result handshakes, and the verdict. Depends on ptw_pkg, the
// walker itself and four_level_page_table_walker_checker.
module four_level_page_table_walker_test;
    import ptw_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT     = 380;
    localparam int HOLD_CYCLES = 300;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;

    int          mismatches;
    int          walks_outstanding;
    int          items_sent = 0;
    int          send_idle_pct = 18;
    int          recv_idle_pct = 77;
    int          cycle_count = 0;
    bit          hold_done = 1'b0;
    logic [63:0] cur_root;
    logic [63:0] cur_base;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    four_level_page_table_walker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    four_level_page_table_walker_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .req               (req),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .rsp               (rsp),
        .mismatches        (mismatches),
        .walks_outstanding (walks_outstanding)
    );

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("four_level_page_table_walker verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off that lets the
    // block fill up and stall its request input.
    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t random_beat();
        req_t b;
        b.mode       = 2'($urandom);
        b.virt_addr  = 48'(rand64());
        b.phys_page  = 52'(rand64());
        b.page_flags = 8'($urandom);
        b.word_index = 12'($urandom);
        b.word_value = rand64();
        return b;
    endfunction

    // Table indices lean on a few popular slots so that walks meet entries
    // written earlier.
    function automatic logic [8:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 9'($urandom_range(0, 3));
        if (r < 75)
            return 9'd511;
        return 9'($urandom);
    endfunction

    // Pages 0 to 7 lie inside the store window, higher ones beyond it.
    function automatic int unsigned pick_page();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 15);
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [63:0] page_addr(input int unsigned page);
        return ((cur_base + 64'hFFF) & ~64'hFFF) + 64'(page) * 64'h1000;
    endfunction

    function automatic logic [11:0] word_of(input logic [63:0] tbl, input logic [8:0] idx);
        return 12'(((tbl - cur_base) >> 3) + 64'(idx));
    endfunction

    function automatic logic [VA_W-1:0] pool_virt(input logic [11:0] ofs);
        return {pick_index(), pick_index(), pick_index(), pick_index(), ofs};
    endfunction

    // Flag bits with the present bit set most of the time.
    function automatic logic [7:0] entry_flags();
        logic [7:0] fl;
        fl    = 8'($urandom);
        fl[0] = ($urandom_range(0, 9) != 0);
        return fl;
    endfunction

    function automatic logic [ADDR_W-1:0] leaf_phys();
        if ($urandom_range(0, 9) == 0)
            return 52'(rand64());
        return 52'(rand64()) & ~52'hFFF;
    endfunction

    task automatic set_register(input logic idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[ADDR_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_ROOT_TABLE)
            cur_root = 64'(value[ADDR_W-1:0]);
        else
            cur_base = 64'(value[ADDR_W-1:0]);
    endtask

    // Offer one request beat, after a random gap, and wait for its acceptance.
    // Valid stays high afterwards so that a following beat can go straight on.
    task automatic send_beat(input req_t beat);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        if (items_sent < 360)
        begin
            send_idle_pct = 18;
            recv_idle_pct = 77;
        end
        else if (items_sent < 720)
        begin
            send_idle_pct = 77;
            recv_idle_pct = 18;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic directed_beat(input logic [1:0] op, input logic [VA_W-1:0] va,
                                 input logic [ADDR_W-1:0] pa, input logic [7:0] fl,
                                 input logic [11:0] wi, input logic [63:0] wv);
        req_t b;
        b.mode       = op;
        b.virt_addr  = va;
        b.phys_page  = pa;
        b.page_flags = fl;
        b.word_index = wi;
        b.word_value = wv;
        send_beat(b);
    endtask

    // Stop offering beats and wait until every result has been taken.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (walks_outstanding != 0)
            @(posedge clk);
    endtask

    // Build the three upper levels for one address, then map it, translate
    // it, and perhaps map it again and unmap it.
    task automatic walk_sequence();
        req_t             b;
        req_t             mapped;
        logic [63:0]      tbl;
        logic [63:0]      nxt;
        logic [VA_W-1:0]  va;
        va  = pool_virt(12'h0);
        tbl = cur_root & ~64'hFFF;
        for (int lvl = 0; lvl < 3; lvl++)
        begin
            nxt          = page_addr(pick_page());
            b            = random_beat();
            b.mode       = MODE_RAW;
            b.word_index = word_of(tbl, 9'(va >> (39 - 9 * lvl)));
            b.word_value = nxt | 64'(entry_flags());
            send_beat(b);
            tbl = nxt;
        end
        b            = random_beat();
        b.mode       = MODE_MAP;
        b.virt_addr  = va;
        b.phys_page  = leaf_phys();
        b.page_flags = entry_flags();
        mapped       = b;
        send_beat(b);
        b           = random_beat();
        b.mode      = MODE_TRANSLATE;
        b.virt_addr = {va[VA_W-1:12], 12'($urandom)};
        send_beat(b);
        // Same value again is accepted; a different one conflicts when the leaf is present.
        if ($urandom_range(0, 1) == 1)
        begin
            b = mapped;
            if ($urandom_range(0, 1) == 1)
                b.phys_page = b.phys_page ^ 52'h1000;
            send_beat(b);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            b           = random_beat();
            b.mode      = MODE_UNMAP;
            b.virt_addr = va;
            send_beat(b);
            b.mode      = MODE_TRANSLATE;
            b.virt_addr = {va[VA_W-1:12], 12'($urandom)};
            send_beat(b);
        end
    endtask

    // Random traffic: mostly table building and walks over it, some single
    // operations on popular addresses, and some entirely random beats.
    task automatic run_phase(input int count);
        int          first;
        int unsigned roll;
        req_t        b;
        first = items_sent;
        while (items_sent - first < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                walk_sequence();
            else
            begin
                b = random_beat();
                if (roll < 55)
                begin
                    b.mode      = MODE_TRANSLATE;
                    b.virt_addr = pool_virt(12'($urandom));
                end
                else if (roll < 72)
                begin
                    b.mode       = ($urandom_range(0, 1) == 1) ? MODE_MAP : MODE_UNMAP;
                    b.virt_addr  = pool_virt(($urandom_range(0, 5) == 0) ? 12'($urandom)
                                                                         : 12'h0);
                    b.phys_page  = leaf_phys();
                    b.page_flags = entry_flags();
                end
                else if (roll < 90)
                begin
                    b.mode       = MODE_RAW;
                    b.word_index = word_of(page_addr(pick_page()), pick_index());
                    b.word_value = page_addr(pick_page()) | 64'(entry_flags());
                end
                send_beat(b);
            end
        end
        drain_results();
    endtask

    task automatic new_setting(input logic [63:0] root, input logic [63:0] base);
        set_register(CFG_ROOT_TABLE, root);
        set_register(CFG_TABLE_BASE, base);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_ROOT_TABLE;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        cur_root  = 64'(ADDR_RESET);
        cur_base  = 64'(ADDR_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        new_setting(64'(ADDR_RESET), 64'(ADDR_RESET));

        // Directed part: build one path by hand, then walk every case on it.
        directed_beat(MODE_TRANSLATE, 48'h0, '0, '0, '0, '0);
        directed_beat(MODE_RAW, '0, '0, '0, 12'd0, page_addr(1) | 64'h1);
        directed_beat(MODE_RAW, '0, '0, '0, 12'd512, page_addr(2) | 64'h3);
        directed_beat(MODE_RAW, '0, '0, '0, 12'd1024, page_addr(3) | 64'h1);
        directed_beat(MODE_TRANSLATE, 48'hABC, '0, '0, '0, '0);
        directed_beat(MODE_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, 8'hFF, '0, '0);
        directed_beat(MODE_TRANSLATE, 48'hFFF, '0, '0, '0, '0);
        directed_beat(MODE_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, 8'hFF, '0, '0);
        directed_beat(MODE_MAP, 48'h0, 52'h5000, 8'h01, '0, '0);
        directed_beat(MODE_MAP, 48'h1, 52'h5000, 8'h01, '0, '0);
        directed_beat(MODE_UNMAP, 48'h800, '0, '0, '0, '0);
        directed_beat(MODE_UNMAP, 48'h0, '0, '0, '0, '0);
        // Unmapping an empty leaf still clears it.
        directed_beat(MODE_UNMAP, 48'h0, '0, '0, '0, '0);
        directed_beat(MODE_TRANSLATE, 48'h0, '0, '0, '0, '0);
        // Unaligned physical page with the present bit clear, then overwritten.
        directed_beat(MODE_MAP, 48'h0, 52'h1_2345_6789_ABC, 8'hFE, '0, '0);
        directed_beat(MODE_MAP, 48'h0, 52'h7000, 8'h01, '0, '0);
        directed_beat(MODE_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
        // A top entry of all ones points far outside the store window.
        directed_beat(MODE_RAW, '0, '0, '0, 12'd511, 64'hFFFF_FFFF_FFFF_FFFF);
        directed_beat(MODE_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
        directed_beat(MODE_MAP, 48'hFFFF_FFFF_F000, 52'h9000, 8'h01, '0, '0);
        // A table just past the end of the window.
        directed_beat(MODE_RAW, '0, '0, '0, 12'd511, page_addr(7) | 64'h1);
        directed_beat(MODE_RAW, '0, '0, '0, 12'd4095, page_addr(8) | 64'h1);
        directed_beat(MODE_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0);
        drain_results();

        run_phase(230);
        new_setting(64'h3ABC, 64'h0);
        run_phase(200);
        new_setting(64'hF_FFFF_FFFF_A000, 64'hF_FFFF_FFFF_8000);
        run_phase(250);
        // Base off page alignment, so table indices can run past the window.
        new_setting(64'h40_1000, 64'h40_0005);
        run_phase(200);
        new_setting(64'hF_FFFF_FFFF_FFFF, 64'hF_FFFF_FFFF_FFFF);
        run_phase(30);
        // Root table below the window.
        new_setting(64'h0, 64'(ADDR_RESET));
        run_phase(20);
        new_setting(64'(ADDR_RESET), 64'(ADDR_RESET));
        run_phase(100);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("four_level_page_table_walker verification clean");
        else
            $display("four_level_page_table_walker verification failed");
        $finish;
    end

endmodule

FILE: four_level_page_table_walker.f
src/ptw_pkg.sv
src/ptw_ctrl.sv
src/ptw_datapath.sv
src/four_level_page_table_walker.sv
tb/sv/four_level_page_table_walker_checker.sv
tb/sv/four_level_page_table_walker_test.sv
